### src/cidbrt_pkg.sv
// types, status codes and the per-frame fold function for the can id byte range tracker
// no dependencies; used by the cell, the top level and the checker
package cidbrt_pkg;

    localparam int ID_W    = 29;
    localparam int DLC_W   = 4;
    localparam int LANES   = 8;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 6;
    localparam int BYTES_W = 8 * LANES;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_UPDATED = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic                   ext;
        logic [DLC_W-1:0]       dlc;
        logic [LANES-1:0][7:0]  data;
    } frame_t;

    typedef struct packed {
        logic                   ext;
        logic [COUNT_W-1:0]     count;
        logic [DLC_W-1:0]       peak;
        logic [BYTES_W-1:0]     minima;
        logic [BYTES_W-1:0]     maxima;
    } entry_t;

    // token travelling down the chain
    typedef struct packed {
        logic vld;
        logic hit;
    } tok_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        entry_t                 entry;
    } res_t;

    function automatic entry_t fresh_entry(logic ext);
        entry_t e;
        e.ext    = ext;
        e.count  = '0;
        e.peak   = '0;
        e.minima = '1;
        e.maxima = '0;
        return e;
    endfunction

    // one frame folded into an entry: count, peak dlc and the byte ranges
    function automatic entry_t fold_frame(entry_t old, frame_t frm);
        entry_t e;
        logic [7:0] lo;
        logic [7:0] hi;
        e = old;
        if (old.count != '1)
        begin
            e.count = old.count + COUNT_W'(1);
        end
        if (frm.dlc > old.peak)
        begin
            e.peak = frm.dlc;
        end
        for (int i = 0; i < LANES; i++)
        begin
            lo = old.minima[8*i +: 8];
            hi = old.maxima[8*i +: 8];
            if (frm.dlc > DLC_W'(i))
            begin
                if (frm.data[i] < lo)
                begin
                    e.minima[8*i +: 8] = frm.data[i];
                end
                if (frm.data[i] > hi)
                begin
                    e.maxima[8*i +: 8] = frm.data[i];
                end
            end
        end
        return e;
    endfunction

endpackage

### src/can_id_byte_range_tracker.sv
// top level of the can id byte range tracker: frame capture and the chain of entry cells
// depends on cidbrt_pkg and cidbrt_cell
//
// Each accepted frame is held and a token walks the row of TABLE_ENTRIES cells, one cell
// per clock; the cell that holds the identifier, or failing that the first free cell,
// folds the frame in and puts its updated entry on the token. done rises when the token
// leaves the last cell, and busy stays high until the edge that ends the done cycle, so a
// new frame is accepted only once the previous one has left the whole cell chain.
// The result is shown for one cycle only and cannot be held off. Entries are claimed in
// order from slot 0; a new identifier arriving with every cell in use is reported as
// dropped with all other result fields zero. Reset empties the table at once.
module can_id_byte_range_tracker
    import cidbrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ID_W-1:0]        frame_id,
    input  logic                   frame_extended,
    input  logic [DLC_W-1:0]       frame_dlc,
    input  logic [7:0]             data_byte0,
    input  logic [7:0]             data_byte1,
    input  logic [7:0]             data_byte2,
    input  logic [7:0]             data_byte3,
    input  logic [7:0]             data_byte4,
    input  logic [7:0]             data_byte5,
    input  logic [7:0]             data_byte6,
    input  logic [7:0]             data_byte7,
    output logic                   done,
    output logic [1:0]             status,
    output logic [SLOT_W-1:0]      slot,
    output logic [COUNT_W-1:0]     seen_count,
    output logic [DLC_W-1:0]       largest_dlc,
    output logic                   stored_extended,
    output logic [BYTES_W-1:0]     low_bytes,
    output logic [BYTES_W-1:0]     high_bytes
);

    logic   accept;
    logic   busy_reg;
    logic   busy_next;
    logic   go_reg;
    frame_t frame_reg;
    tok_t   tail_tok;
    res_t   tail_res;

    tok_t chain_tok [TABLE_ENTRIES+1];
    res_t chain_res [TABLE_ENTRIES+1];

    assign accept = start && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail_tok.vld)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            go_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            go_reg   <= accept;
        end
    end

    // frame stays put while the token walks the chain
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg.id   <= frame_id;
            frame_reg.ext  <= frame_extended;
            frame_reg.dlc  <= frame_dlc;
            frame_reg.data <= {data_byte7, data_byte6, data_byte5, data_byte4,
                               data_byte3, data_byte2, data_byte1, data_byte0};
        end
    end

    assign chain_tok[0].vld = go_reg;
    assign chain_tok[0].hit = 1'b0;
    assign chain_res[0]     = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        cidbrt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .frm     (frame_reg),
            .tok_in  (chain_tok[g]),
            .res_in  (chain_res[g]),
            .tok_out (chain_tok[g+1]),
            .res_out (chain_res[g+1])
        );
    end

    assign tail_tok = chain_tok[TABLE_ENTRIES];
    assign tail_res = chain_res[TABLE_ENTRIES];

    // a token that left the chain without a hit found the table full
    assign busy            = busy_reg;
    assign done            = tail_tok.vld;
    assign status          = tail_tok.hit ? tail_res.status : ST_DROPPED;
    assign slot            = tail_tok.hit ? tail_res.slot : '0;
    assign seen_count      = tail_tok.hit ? tail_res.entry.count : '0;
    assign largest_dlc     = tail_tok.hit ? tail_res.entry.peak : '0;
    assign stored_extended = tail_tok.hit && tail_res.entry.ext;
    assign low_bytes       = tail_tok.hit ? tail_res.entry.minima : '0;
    assign high_bytes      = tail_tok.hit ? tail_res.entry.maxima : '0;

endmodule

### src/cidbrt_cell.sv
// one table entry of the tracker with its match, claim and update logic
// depends on cidbrt_pkg
module cidbrt_cell
    import cidbrt_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  frame_t frm,
    input  tok_t   tok_in,
    input  res_t   res_in,
    output tok_t   tok_out,
    output res_t   res_out
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic            valid_reg;
    logic            valid_next;
    logic [ID_W-1:0] key_reg;
    entry_t          entry_reg;
    tok_t            tok_reg;
    tok_t            tok_next;
    res_t            res_reg;
    res_t            res_next;

    logic   hit;
    logic   claim;
    logic   act;
    entry_t base;
    entry_t upd;

    always_comb
    begin
        hit   = valid_reg && (key_reg == frm.id);
        claim = !valid_reg;
        act   = tok_in.vld && !tok_in.hit && (hit || claim);
        base  = claim ? fresh_entry(frm.ext) : entry_reg;
        upd   = fold_frame(base, frm);

        valid_next   = valid_reg || act;
        tok_next.vld = tok_in.vld;
        tok_next.hit = tok_in.hit || act;

        res_next = res_in;
        if (act)
        begin
            res_next.status = claim ? ST_NEW : ST_UPDATED;
            res_next.slot   = MY_SLOT;
            res_next.entry  = upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act)
        begin
            key_reg   <= frm.id;
            entry_reg <= upd;
        end
        res_reg <= res_next;
    end

    assign tok_out = tok_reg;
    assign res_out = res_reg;

endmodule

### src/cidbrt_checker.sv
// port-level checks for the can id byte range tracker, attached by bind
// depends on cidbrt_pkg and can_id_byte_range_tracker
module cidbrt_checker
    import cidbrt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic [SLOT_W-1:0]  slot,
    input logic [COUNT_W-1:0] seen_count
);

    // a result only ever belongs to a transaction in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a transaction in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transaction was accepted");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after the result");

    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NEW) |-> (seen_count == COUNT_W'(1)))
        else $error("new entry reported with a count other than one");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DROPPED) |-> (slot == '0 && seen_count == '0))
        else $error("dropped frame reported with non-zero fields");

endmodule

bind can_id_byte_range_tracker cidbrt_checker u_cidbrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .slot       (slot),
    .seen_count (seen_count)
);
